/* rtl/cbccp_pkg.sv */
// Shared types and constants for the byte-capacity CLOCK cache policy block.
// Used by the controller, the datapath and the top level; depends on nothing.
package cbccp_pkg;

   localparam int CBCCP_ENTRIES = 32;
   localparam logic [39:0] CAPACITY_RESET = 40'd67108864;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_ACCESS = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;
   localparam logic [1:0] OP_FORCE  = 2'd3;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_PRESENT  = 3'd1;
   localparam logic [2:0] ST_NOTFOUND = 3'd2;
   localparam logic [2:0] ST_ZERO     = 3'd3;
   localparam logic [2:0] ST_FULL     = 3'd4;

   localparam logic KIND_EVICT = 1'b0;
   localparam logic KIND_FINAL = 1'b1;

   localparam int UOP_W = 4;
   localparam logic [UOP_W-1:0] UOP_NONE      = 4'd0;
   localparam logic [UOP_W-1:0] UOP_ACCEPT    = 4'd1;
   localparam logic [UOP_W-1:0] UOP_READ_SCAN = 4'd2;
   localparam logic [UOP_W-1:0] UOP_COMPARE   = 4'd3;
   localparam logic [UOP_W-1:0] UOP_INSERT    = 4'd4;
   localparam logic [UOP_W-1:0] UOP_PARK      = 4'd5;
   localparam logic [UOP_W-1:0] UOP_READ_HAND = 4'd6;
   localparam logic [UOP_W-1:0] UOP_SPIN      = 4'd7;
   localparam logic [UOP_W-1:0] UOP_EVICT     = 4'd8;
   localparam logic [UOP_W-1:0] UOP_REMOVE    = 4'd9;
   localparam logic [UOP_W-1:0] UOP_SET_REF   = 4'd10;
   localparam logic [UOP_W-1:0] UOP_FV_STEP   = 4'd11;
   localparam logic [UOP_W-1:0] UOP_EMIT_REP  = 4'd12;
   localparam logic [UOP_W-1:0] UOP_EMIT_FIN  = 4'd13;

   typedef struct packed {
      logic [UOP_W-1:0] uop;
      logic [2:0]       code;
   } cbccp_cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       amt_zero;
      logic       found;
      logic       match;
      logic       scan_last;
      logic       full;
      logic       over;
      logic       fv_go;
      logic       sc_take;
      logic       out_free;
   } cbccp_stat_type;

endpackage

/* rtl/cbccp_dp.sv */
// Datapath of the cache policy block: slot memories, links, hand, counters
// and the result register. Depends on cbccp_pkg and is driven by cbccp_ctrl.
module cbccp_dp import cbccp_pkg::*; #(
   parameter int ENTRIES = CBCCP_ENTRIES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [39:0]           csr_write_data,
   input  logic [1:0]            req_opcode,
   input  logic [31:0]           req_key,
   input  logic [31:0]           req_amount,
   input  cbccp_cmd_type         cmd,
   output cbccp_stat_type        stat,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic                  rsp_kind,
   output logic [2:0]            rsp_status,
   output logic [31:0]           rsp_entry_key,
   output logic [36:0]           rsp_bytes,
   output logic [36:0]           rsp_used_total,
   output logic                  rsp_last
);

   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int SPIN_W = CNT_W + 1;
   localparam int BUD_W  = $clog2(3 * ENTRIES + 5);

   logic [31:0]      key_mem   [ENTRIES];
   logic [31:0]      size_mem  [ENTRIES];
   logic [IDX_W-1:0] newer_mem [ENTRIES];
   logic [IDX_W-1:0] older_mem [ENTRIES];

   logic [31:0]      key_rd_ff, size_rd_ff;
   logic [IDX_W-1:0] newer_rd_ff, older_rd_ff;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;

   logic             key_we, size_we, newer_we, older_we;
   logic [IDX_W-1:0] key_wa, size_wa, newer_wa, older_wa;
   logic [31:0]      key_wd, size_wd;
   logic [IDX_W-1:0] newer_wd, older_wd;

   logic [39:0]        capacity_ff;
   logic [ENTRIES-1:0] valid_ff, valid_in, ref_ff, ref_in;
   logic [IDX_W-1:0]   newest_ff, newest_in, oldest_ff, oldest_in, hand_ff, hand_in;
   logic               parked_ff, parked_in;
   logic [CNT_W-1:0]   live_ff, live_in;
   logic [36:0]        used_ff, used_in;
   logic [1:0]         op_ff, op_in;
   logic [31:0]        key_ff, key_in, amt_ff, amt_in;
   logic [IDX_W-1:0]   scan_ff, scan_in, slot_ff, slot_in, free_ff, free_in;
   logic               found_ff, found_in, free_seen_ff, free_seen_in;
   logic [SPIN_W-1:0]  spins_ff, spins_in;
   logic [BUD_W-1:0]   swept_ff, swept_in, budget_ff, budget_in;
   logic [36:0]        freed_ff, freed_in;
   logic [31:0]        ev_key_ff, ev_key_in, ev_size_ff, ev_size_in;

   logic        rsp_valid_ff, rsp_valid_in, rsp_kind_ff, rsp_kind_in;
   logic        rsp_last_ff, rsp_last_in;
   logic [2:0]  rsp_status_ff, rsp_status_in;
   logic [31:0] rsp_key_ff, rsp_key_in;
   logic [36:0] rsp_bytes_ff, rsp_bytes_in, rsp_used_ff, rsp_used_in;

   logic [IDX_W-1:0] cur;
   logic             do_adv;
   logic [36:0]      fin_bytes;

   assign rd_en   = (cmd.uop == UOP_READ_SCAN) || (cmd.uop == UOP_READ_HAND);
   assign rd_addr = (cmd.uop == UOP_READ_SCAN) ? scan_ff : hand_ff;
   assign cur     = (cmd.uop == UOP_REMOVE) ? slot_ff : hand_ff;
   assign do_adv  = (cmd.uop == UOP_EVICT) || (!parked_ff && hand_ff == slot_ff);

   always_ff @(posedge clock) begin
      if (key_we) key_mem[key_wa] <= key_wd;
      if (size_we) size_mem[size_wa] <= size_wd;
      if (newer_we) newer_mem[newer_wa] <= newer_wd;
      if (older_we) older_mem[older_wa] <= older_wd;
      if (rd_en) begin
         key_rd_ff   <= key_mem[rd_addr];
         size_rd_ff  <= size_mem[rd_addr];
         newer_rd_ff <= newer_mem[rd_addr];
         older_rd_ff <= older_mem[rd_addr];
      end
   end

   assign stat.op        = op_ff;
   assign stat.amt_zero  = (amt_ff == 32'd0);
   assign stat.found     = found_ff;
   assign stat.match     = valid_ff[scan_ff] && (key_rd_ff == key_ff);
   assign stat.scan_last = (scan_ff == IDX_W'(ENTRIES - 1));
   assign stat.full      = (live_ff >= CNT_W'(ENTRIES));
   assign stat.over      = ({3'b000, used_ff} > capacity_ff) && (live_ff > CNT_W'(1));
   assign stat.fv_go     = (freed_ff < {5'b00000, amt_ff}) && (live_ff != '0)
                           && (swept_ff < budget_ff);
   assign stat.sc_take   = ref_ff[hand_ff] && (spins_ff < {live_ff, 1'b0});
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      priority if (cmd.code != ST_OK) fin_bytes = '0;
      else if (op_ff == OP_INSERT) fin_bytes = {5'b00000, amt_ff};
      else if (op_ff == OP_ACCESS) fin_bytes = {5'b00000, size_rd_ff};
      else if (op_ff == OP_REMOVE) fin_bytes = {5'b00000, ev_size_ff};
      else fin_bytes = freed_ff;
   end

   always_comb begin
      valid_in = valid_ff;     ref_in = ref_ff;
      newest_in = newest_ff;   oldest_in = oldest_ff;
      hand_in = hand_ff;       parked_in = parked_ff;
      live_in = live_ff;       used_in = used_ff;
      op_in = op_ff;           key_in = key_ff;         amt_in = amt_ff;
      scan_in = scan_ff;       slot_in = slot_ff;       free_in = free_ff;
      found_in = found_ff;     free_seen_in = free_seen_ff;
      spins_in = spins_ff;     swept_in = swept_ff;     budget_in = budget_ff;
      freed_in = freed_ff;     ev_key_in = ev_key_ff;   ev_size_in = ev_size_ff;
      key_we = 1'b0;   key_wa = free_ff;   key_wd = key_ff;
      size_we = 1'b0;  size_wa = free_ff;  size_wd = amt_ff;
      newer_we = 1'b0; newer_wa = older_rd_ff; newer_wd = newer_rd_ff;
      older_we = 1'b0; older_wa = newer_rd_ff; older_wd = older_rd_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      rsp_kind_in = rsp_kind_ff;     rsp_status_in = rsp_status_ff;
      rsp_key_in = rsp_key_ff;       rsp_bytes_in = rsp_bytes_ff;
      rsp_used_in = rsp_used_ff;     rsp_last_in = rsp_last_ff;
      unique case (cmd.uop)
         UOP_ACCEPT: begin
            op_in = req_opcode;
            key_in = req_key;
            amt_in = req_amount;
            scan_in = '0;
            found_in = 1'b0;
            free_seen_in = 1'b0;
            spins_in = '0;
            swept_in = '0;
            freed_in = '0;
            budget_in = BUD_W'(3) * BUD_W'(live_ff) + BUD_W'(4);
         end
         UOP_COMPARE: begin
            if (stat.match) begin
               found_in = 1'b1;
               slot_in = scan_ff;
            end
            if (!valid_ff[scan_ff] && !free_seen_ff) begin
               free_in = scan_ff;
               free_seen_in = 1'b1;
            end
            scan_in = scan_ff + IDX_W'(1);
         end
         UOP_INSERT: begin
            key_we = 1'b1;
            size_we = 1'b1;
            valid_in[free_ff] = 1'b1;
            ref_in[free_ff] = 1'b0;
            if (live_ff == '0) begin
               oldest_in = free_ff;
            end else begin
               newer_we = 1'b1;
               newer_wa = newest_ff;
               newer_wd = free_ff;
               older_we = 1'b1;
               older_wa = free_ff;
               older_wd = newest_ff;
            end
            newest_in = free_ff;
            live_in = live_ff + CNT_W'(1);
            used_in = used_ff + {5'b00000, amt_ff};
         end
         UOP_PARK: begin
            if (parked_ff) begin
               hand_in = oldest_ff;
               parked_in = 1'b0;
            end
         end
         UOP_SPIN: begin
            spins_in = spins_ff + SPIN_W'(1);
            ref_in[hand_ff] = 1'b0;
            if (hand_ff == newest_ff) parked_in = 1'b1;
            else hand_in = newer_rd_ff;
         end
         UOP_EVICT, UOP_REMOVE: begin
            if (do_adv) begin
               if (cur == newest_ff) parked_in = 1'b1;
               else hand_in = newer_rd_ff;
            end
            if (live_ff > CNT_W'(1)) begin
               if (cur != newest_ff) older_we = 1'b1;
               if (cur != oldest_ff) newer_we = 1'b1;
               if (cur == newest_ff) newest_in = older_rd_ff;
               if (cur == oldest_ff) oldest_in = newer_rd_ff;
            end
            valid_in[cur] = 1'b0;
            ref_in[cur] = 1'b0;
            live_in = live_ff - CNT_W'(1);
            used_in = used_ff - {5'b00000, size_rd_ff};
            ev_key_in = key_rd_ff;
            ev_size_in = size_rd_ff;
            freed_in = freed_ff + {5'b00000, size_rd_ff};
         end
         UOP_SET_REF: ref_in[slot_ff] = 1'b1;
         UOP_FV_STEP: begin
            if ((freed_ff < {5'b00000, amt_ff}) && (live_ff != '0)) begin
               swept_in = swept_ff + BUD_W'(1);
            end
         end
         UOP_EMIT_REP: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in = KIND_EVICT;
            rsp_status_in = ST_OK;
            rsp_key_in = ev_key_ff;
            rsp_bytes_in = {5'b00000, ev_size_ff};
            rsp_used_in = used_ff;
            rsp_last_in = 1'b0;
         end
         UOP_EMIT_FIN: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in = KIND_FINAL;
            rsp_status_in = cmd.code;
            rsp_key_in = key_ff;
            rsp_bytes_in = fin_bytes;
            rsp_used_in = used_ff;
            rsp_last_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
         valid_ff <= '0;
         ref_ff <= '0;
         newest_ff <= '0;
         oldest_ff <= '0;
         hand_ff <= '0;
         parked_ff <= 1'b1;
         live_ff <= '0;
         used_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) capacity_ff <= csr_write_data;
         valid_ff <= valid_in;
         ref_ff <= ref_in;
         newest_ff <= newest_in;
         oldest_ff <= oldest_in;
         hand_ff <= hand_in;
         parked_ff <= parked_in;
         live_ff <= live_in;
         used_ff <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      key_ff <= key_in;
      amt_ff <= amt_in;
      scan_ff <= scan_in;
      slot_ff <= slot_in;
      free_ff <= free_in;
      found_ff <= found_in;
      free_seen_ff <= free_seen_in;
      spins_ff <= spins_in;
      swept_ff <= swept_in;
      budget_ff <= budget_in;
      freed_ff <= freed_in;
      ev_key_ff <= ev_key_in;
      ev_size_ff <= ev_size_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff <= rsp_key_in;
      rsp_bytes_ff <= rsp_bytes_in;
      rsp_used_ff <= rsp_used_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_entry_key  = rsp_key_ff;
   assign rsp_bytes      = rsp_bytes_ff;
   assign rsp_used_total = rsp_used_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

/* rtl/cbccp_ctrl.sv */
// Controller of the cache policy block: sequences the key scan, insert,
// eviction loops and result emission. Depends on cbccp_pkg; drives cbccp_dp.
module cbccp_ctrl import cbccp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  cbccp_stat_type stat,
   output cbccp_cmd_type  cmd
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_SCAN_RD  = 4'd1;
   localparam logic [3:0] S_SCAN_CMP = 4'd2;
   localparam logic [3:0] S_DECIDE   = 4'd3;
   localparam logic [3:0] S_INSERT   = 4'd4;
   localparam logic [3:0] S_EV_CHECK = 4'd5;
   localparam logic [3:0] S_EV_PARK  = 4'd6;
   localparam logic [3:0] S_EV_RD    = 4'd7;
   localparam logic [3:0] S_EV_DEC   = 4'd8;
   localparam logic [3:0] S_ACCESS   = 4'd9;
   localparam logic [3:0] S_REMOVE   = 4'd10;
   localparam logic [3:0] S_EMIT_REP = 4'd11;
   localparam logic [3:0] S_EMIT_FIN = 4'd12;
   localparam logic [3:0] S_FV_CHECK = 4'd13;

   logic [3:0] state_ff, state_in;
   logic [2:0] code_ff, code_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      code_in = code_ff;
      cmd.uop = UOP_NONE;
      cmd.code = code_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.uop = UOP_ACCEPT;
               code_in = ST_OK;
               state_in = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            if (stat.op == OP_FORCE) begin
               state_in = S_FV_CHECK;
            end else begin
               cmd.uop = UOP_READ_SCAN;
               state_in = S_SCAN_CMP;
            end
         end
         S_SCAN_CMP: begin
            cmd.uop = UOP_COMPARE;
            state_in = (stat.match || stat.scan_last) ? S_DECIDE : S_SCAN_RD;
         end
         S_DECIDE: begin
            state_in = S_EMIT_FIN;
            priority if (stat.op == OP_INSERT) begin
               priority if (stat.amt_zero) code_in = ST_ZERO;
               else if (stat.found) code_in = ST_PRESENT;
               else if (stat.full) code_in = ST_FULL;
               else state_in = S_INSERT;
            end else if (!stat.found) begin
               code_in = ST_NOTFOUND;
            end else if (stat.op == OP_ACCESS) begin
               state_in = S_ACCESS;
            end else begin
               state_in = S_REMOVE;
            end
         end
         S_INSERT: begin
            cmd.uop = UOP_INSERT;
            state_in = S_EV_CHECK;
         end
         S_EV_CHECK: begin
            state_in = stat.over ? S_EV_PARK : S_EMIT_FIN;
         end
         S_FV_CHECK: begin
            cmd.uop = UOP_FV_STEP;
            state_in = stat.fv_go ? S_EV_PARK : S_EMIT_FIN;
         end
         S_EV_PARK: begin
            cmd.uop = UOP_PARK;
            state_in = S_EV_RD;
         end
         S_EV_RD: begin
            cmd.uop = UOP_READ_HAND;
            state_in = S_EV_DEC;
         end
         S_EV_DEC: begin
            if (stat.op == OP_INSERT && stat.sc_take) begin
               cmd.uop = UOP_SPIN;
               state_in = S_EV_CHECK;
            end else begin
               cmd.uop = UOP_EVICT;
               state_in = S_EMIT_REP;
            end
         end
         S_EMIT_REP: begin
            if (stat.out_free) begin
               cmd.uop = UOP_EMIT_REP;
               state_in = (stat.op == OP_FORCE) ? S_FV_CHECK : S_EV_CHECK;
            end
         end
         S_ACCESS: begin
            cmd.uop = UOP_SET_REF;
            state_in = S_EMIT_FIN;
         end
         S_REMOVE: begin
            cmd.uop = UOP_REMOVE;
            state_in = S_EMIT_FIN;
         end
         S_EMIT_FIN: begin
            if (stat.out_free) begin
               cmd.uop = UOP_EMIT_FIN;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         code_ff <= ST_OK;
      end else begin
         state_ff <= state_in;
         code_ff <= code_in;
      end
   end

endmodule

/* rtl/clock_byte_capacity_cache_policy.sv */
// Top level of the byte-capacity CLOCK cache policy block.
// Instantiates cbccp_ctrl and cbccp_dp; depends on cbccp_pkg.
//
// Requests arrive on the req_ channel as one word each: opcode, key and
// amount. Every request yields zero or more eviction reports followed by one
// final word with rsp_last set, all on the rsp_ channel. The capacity register
// is written through csr_write_enable and csr_write_data; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// Insert, access and remove scan the slot table through the key memory, a read
// and a compare per slot, and stop early on a hit. Each eviction step of the hand
// runs through check, park, hand read, decide and report states, and a second chance
// through check, park, hand read and decide; the report waits while the receiver stalls.
// Force evict skips the scan. One request is in flight at a time.
// The result register lets the final word wait while the next request is
// taken. When the receiver stalls, the sequencer holds before the next report.
// Reset empties the table, parks the hand and loads the default capacity.
module clock_byte_capacity_cache_policy import cbccp_pkg::*; #(
   parameter int ENTRIES = CBCCP_ENTRIES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [39:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_key,
   input  logic [31:0] req_amount,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_entry_key,
   output logic [36:0] rsp_bytes,
   output logic [36:0] rsp_used_total,
   output logic        rsp_last
);

   cbccp_cmd_type  cmd;
   cbccp_stat_type stat;

   cbccp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   cbccp_dp #(.ENTRIES(ENTRIES)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_opcode       (req_opcode),
      .req_key          (req_key),
      .req_amount       (req_amount),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_kind         (rsp_kind),
      .rsp_status       (rsp_status),
      .rsp_entry_key    (rsp_entry_key),
      .rsp_bytes        (rsp_bytes),
      .rsp_used_total   (rsp_used_total),
      .rsp_last         (rsp_last)
   );

   a_last_is_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == rsp_kind))
      else $error("Final flag and word kind disagree.");

   a_report_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_EVICT) |-> (rsp_status == ST_OK && rsp_bytes[36:32] == 5'd0))
      else $error("Eviction report carries a bad status or size.");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("A second request was taken while one is in flight.");

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for clock_byte_capacity_cache_policy: drives
// insert, access, remove and force-evict words and checks every result word.
// Depends on cbccp_pkg and the RTL of the block.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import cbccp_pkg::*;

   localparam int NSLOT = CBCCP_ENTRIES;
   localparam int IDLE_LIMIT = 20000;

   typedef struct packed {
      logic        kind;
      logic [2:0]  status;
      logic [31:0] entry_key;
      logic [36:0] bytes;
      logic [36:0] used_total;
      logic        last;
   } result_word_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_write_enable = 0;
   logic [39:0] csr_write_data = '0;
   logic        req_valid = 0;
   logic        req_ready;
   logic [1:0]  req_opcode = OP_INSERT;
   logic [31:0] req_key = '0;
   logic [31:0] req_amount = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic        rsp_kind;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_entry_key;
   logic [36:0] rsp_bytes;
   logic [36:0] rsp_used_total;
   logic        rsp_last;

   clock_byte_capacity_cache_policy uut (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_ready(req_ready), .req_opcode(req_opcode),
      .req_key(req_key), .req_amount(req_amount),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_kind(rsp_kind),
      .rsp_status(rsp_status), .rsp_entry_key(rsp_entry_key), .rsp_bytes(rsp_bytes),
      .rsp_used_total(rsp_used_total), .rsp_last(rsp_last)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Model of the cache table.
   logic [39:0] capacity;
   logic        live [NSLOT];
   logic [31:0] tag [NSLOT];
   logic [31:0] size [NSLOT];
   logic        refd [NSLOT];
   int          newer [NSLOT];
   int          older [NSLOT];
   int          newest, oldest, hand, count;
   logic        parked;
   logic [36:0] used;

   result_word_type pending_results[$];
   int   errors = 0;
   int   idle_cycles = 0;
   bit   hold_off = 0;
   bit   rsp_stall_on = 1;

   function automatic void table_reset();
      capacity = CAPACITY_RESET;
      for (int i = 0; i < NSLOT; i++) begin
         live[i] = 0; refd[i] = 0; tag[i] = 0; size[i] = 0;
         newer[i] = 0; older[i] = 0;
      end
      newest = 0; oldest = 0; hand = 0; parked = 1; count = 0; used = 0;
   endfunction

   function automatic void push_result(logic kind, logic [2:0] st, logic [31:0] k,
                                       logic [36:0] b, logic lst);
      result_word_type r;
      r.kind = kind; r.status = st; r.entry_key = k; r.bytes = b;
      r.used_total = used; r.last = lst;
      pending_results = {pending_results, r};
   endfunction

   function automatic int lookup(logic [31:0] k);
      for (int i = 0; i < NSLOT; i++)
         if (live[i] && tag[i] == k) return i;
      return -1;
   endfunction

   function automatic void step_hand(int cur);
      if (cur == newest) parked = 1;
      else hand = newer[cur];
   endfunction

   function automatic void unlink(int s);
      int o, nw;
      o = older[s];
      nw = newer[s];
      if (count > 1) begin
         if (s != newest) older[nw] = o;
         if (s != oldest) newer[o] = nw;
         if (s == newest) newest = o;
         if (s == oldest) oldest = nw;
      end
      live[s] = 0;
      refd[s] = 0;
      if (count > 0) count--;
      used = used - 37'(size[s]);
   endfunction

   function automatic logic [36:0] evict_hand();
      int cur;
      logic [36:0] sz;
      cur = hand;
      sz = 37'(size[cur]);
      step_hand(cur);
      unlink(cur);
      push_result(KIND_EVICT, ST_OK, tag[cur], sz, 1'b0);
      return sz;
   endfunction

   function automatic void predict_word(logic [1:0] op, logic [31:0] k, logic [31:0] amt);
      int f, s, spins, limit, swept, budget;
      logic [36:0] freed, sz;
      case (op)
         OP_INSERT: begin
            if (amt == 0) push_result(KIND_FINAL, ST_ZERO, k, '0, 1'b1);
            else if (lookup(k) >= 0) push_result(KIND_FINAL, ST_PRESENT, k, '0, 1'b1);
            else if (count >= NSLOT) push_result(KIND_FINAL, ST_FULL, k, '0, 1'b1);
            else begin
               s = 0;
               while (s < NSLOT && live[s]) s++;
               live[s] = 1; tag[s] = k; size[s] = amt; refd[s] = 0;
               if (count == 0) begin
                  newest = s; oldest = s;
               end else begin
                  newer[newest] = s; older[s] = newest; newest = s;
               end
               count++;
               used = used + 37'(amt);
               spins = 0;
               while ({3'b0, used} > capacity && count > 1) begin
                  limit = 2 * count;
                  if (parked) begin
                     hand = oldest; parked = 0;
                  end
                  if (refd[hand] && ++spins <= limit) begin
                     refd[hand] = 0;
                     step_hand(hand);
                  end else void'(evict_hand());
               end
               push_result(KIND_FINAL, ST_OK, k, 37'(amt), 1'b1);
            end
         end
         OP_ACCESS: begin
            f = lookup(k);
            if (f < 0) push_result(KIND_FINAL, ST_NOTFOUND, k, '0, 1'b1);
            else begin
               refd[f] = 1;
               push_result(KIND_FINAL, ST_OK, k, 37'(size[f]), 1'b1);
            end
         end
         OP_REMOVE: begin
            f = lookup(k);
            if (f < 0) push_result(KIND_FINAL, ST_NOTFOUND, k, '0, 1'b1);
            else begin
               sz = 37'(size[f]);
               if (!parked && hand == f) step_hand(f);
               unlink(f);
               push_result(KIND_FINAL, ST_OK, k, sz, 1'b1);
            end
         end
         default: begin
            freed = 0;
            swept = 0;
            budget = 3 * count + 4;
            while (freed < 37'(amt) && count > 0 && swept++ < budget) begin
               if (parked) begin
                  hand = oldest; parked = 0;
               end
               freed += evict_hand();
            end
            push_result(KIND_FINAL, ST_OK, k, freed, 1'b1);
         end
      endcase
   endfunction

   // Sender: bursts and gaps.
   int burst_left = 0;

   task automatic send_word(logic [1:0] op, logic [31:0] k, logic [31:0] amt);
      if (burst_left == 0) begin
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_valid <= 1;
      req_opcode <= op;
      req_key <= k;
      req_amount <= amt;
      do @(posedge clock); while (!req_ready);
      predict_word(op, k, amt);
      if (burst_left == 0) req_valid <= 0;
   endtask

   task automatic wait_idle();
      if (burst_left != 0) begin
         req_valid <= 0;
         burst_left = 0;
      end
      while (pending_results.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_capacity(logic [39:0] v);
      wait_idle();
      csr_write_enable <= 1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 0;
      capacity = v;
   endtask

   // Receiver stall pattern plus one long hold-off.
   always @(posedge clock) begin
      if (reset || hold_off) rsp_ready <= 0;
      else if (!rsp_stall_on) rsp_ready <= 1;
      else rsp_ready <= ($urandom_range(0, 3) != 0);
   end

   always @(posedge clock) begin
      result_word_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_kind, rsp_status, rsp_entry_key, rsp_bytes, rsp_used_total, rsp_last};
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result word %h", $time, got);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (got.kind !== want.kind)
               $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
            if (got.status !== want.status)
               $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            if (got.entry_key !== want.entry_key)
               $display("%0t: entry_key expected %h actual %h", $time, want.entry_key,
                        got.entry_key);
            if (got.bytes !== want.bytes)
               $display("%0t: bytes expected %0d actual %0d", $time, want.bytes, got.bytes);
            if (got.used_total !== want.used_total)
               $display("%0t: used_total expected %0d actual %0d", $time, want.used_total,
                        got.used_total);
            if (got.last !== want.last)
               $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
            if (got !== want) errors++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || hold_off)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("clock_byte_capacity_cache_policy regression: fail");
         $finish;
      end
   end

   function automatic logic [31:0] pick_key();
      return 32'hA000_0000 | $urandom_range(0, 47);
   endfunction

   task automatic test_directed();
      send_word(OP_INSERT, 32'h1, 0);
      send_word(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(OP_INSERT, 32'hFFFF_FFFF, 32'h5);
      send_word(OP_ACCESS, 32'hFFFF_FFFF, 0);
      send_word(OP_ACCESS, 32'h0, 32'hFFFF_FFFF);
      send_word(OP_REMOVE, 32'h0, 0);
      send_word(OP_INSERT, 32'h0, 32'h10);
      send_word(OP_INSERT, 32'h2, 32'h20);
      send_word(OP_REMOVE, 32'h2, 0);
      send_word(OP_FORCE, 32'h7, 0);
      send_word(OP_FORCE, 32'h7, 32'hFFFF_FFFF);
      send_word(OP_FORCE, 32'h7, 32'h1);
   endtask

   task automatic test_full_table();
      for (int i = 0; i < NSLOT + 2; i++) send_word(OP_INSERT, 32'h100 + i, 32'h40 + i);
      send_word(OP_REMOVE, 32'h105, 0);
      send_word(OP_INSERT, 32'h200, 1);
      send_word(OP_FORCE, 0, 32'hFFFF_FFFF);
   endtask

   task automatic test_second_chance(logic [39:0] cap, int n);
      logic [1:0] op;
      write_capacity(cap);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: op = OP_INSERT;
            4, 5, 6: op = OP_ACCESS;
            7, 8: op = OP_REMOVE;
            default: op = OP_FORCE;
         endcase
         send_word(op, ($urandom_range(0, 15) == 0) ? $urandom() : pick_key(),
                   ($urandom_range(0, 20) == 0) ? $urandom() :
                   ($urandom_range(0, 20) == 0) ? 32'h0 : $urandom_range(1, 600));
      end
   endtask

   task automatic test_back_pressure();
      wait_idle();
      rsp_stall_on = 0;
      fork
         begin
            hold_off = 1;
            repeat (300) @(posedge clock);
            hold_off = 0;
         end
         for (int i = 0; i < 10; i++) send_word(OP_ACCESS, pick_key(), 0);
      join
      rsp_stall_on = 1;
   endtask

   initial begin
      table_reset();
      repeat (10) @(posedge clock);
      reset <= 0;
      test_directed();
      test_full_table();
      write_capacity(40'hFF_FFFF_FFFF);
      test_second_chance(40'd0, 60);
      test_second_chance(40'd2000, 120);
      test_back_pressure();
      test_second_chance(40'd5000, 80);
      test_second_chance(40'hFF_FFFF_FFFF, 40);
      wait_idle();
      if (errors == 0) $display("clock_byte_capacity_cache_policy regression: pass");
      else $display("clock_byte_capacity_cache_policy regression: fail");
      $finish;
   end
endmodule
